/* sv/bfc_pkg.sv */
// Package: shared widths, codes and state type of the FIR convolver.
`timescale 1ns / 1ps
`default_nettype none

package bfc_pkg;

    // Field widths of the item and result channels
    localparam int ACTION_W     = 2;
    localparam int TAP_INDEX_W  = 10;
    localparam int TAP_COUNT_W  = 11;
    localparam int SAMPLE_W     = 24;
    localparam int FRAC_BITS    = 23;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_TAPS = 1024;
    localparam int DEF_CHANNELS = 2;

    // Tap count after reset
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 11'd1024;

    // Saturation limits, Q1.23
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    // Item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_COEF   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* sv/bfc_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* sv/block_fir_convolver.sv */
// Top level: multichannel direct-form FIR convolver with RAM-held taps and history.
//
// Each processed sample on channel ch returns y = sum over k below tap_count of
// coef[ch][k] * x[ch][n-k], Q1.23, floored by 23 bits and saturated, with a flag
// on clipping. Coefficients and sample history sit in two single-port RAMs that
// are walked one tap per cycle by one 24x24 multiplier and an accumulator; the
// item channel stalls until a sample item is done, while coefficient writes and
// history clears do not stall it and give no result. History is not swept on a
// clear: a per-channel fill count makes slots older than the last clear read as
// zero. After reset the coefficient RAM is zeroed one entry a cycle, over all
// 2^(CH_W+clog2(MAX_TAPS)) entries, CH_W being clog2(CHANNELS) but at least 1
// (2048 at the defaults); item_stall
// is high meanwhile, but tap_count writes are taken at any time. A finished
// result waits in an output register and does not hold up the next item.
`timescale 1ns / 1ps
`default_nettype none

module block_fir_convolver
    import bfc_pkg::*;
#(
    parameter int MAX_TAPS = DEF_MAX_TAPS,
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [TAP_COUNT_W-1:0] tap_count,
    // item channel
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic        [ACTION_W-1:0]    action,
    input  wire logic                          channel,
    input  wire logic        [TAP_INDEX_W-1:0] tap_index,
    input  wire logic signed [SAMPLE_W-1:0]    value,
    // result channel
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic signed      [SAMPLE_W-1:0]    sample_out,
    output logic                               channel_out,
    output logic                               saturated
);

    localparam int TAP_W  = $clog2(MAX_TAPS);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = CH_W + TAP_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int TOP_W  = ACC_W - (FRAC_BITS + SAMPLE_W - 1);

    localparam logic [TAP_W-1:0] LAST_SLOT = TAP_W'(MAX_TAPS - 1);
    localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(MAX_TAPS);

    // Control state
    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic [TAP_W-1:0]        pos_reg, pos_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [CNT_W-1:0]        taps_reg, taps_next;
    logic [CNT_W-1:0]        fill_cur_reg, fill_cur_next;
    logic [TAP_W-1:0]        ptr_reg  [2**CH_W];
    logic [TAP_W-1:0]        ptr_next [2**CH_W];
    logic [CNT_W-1:0]        fill_reg  [2**CH_W];
    logic [CNT_W-1:0]        fill_next [2**CH_W];
    logic [TAP_COUNT_W-1:0]  tap_count_reg, tap_count_next;
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic                    result_valid_reg, result_valid_next;

    // Datapath
    logic                       s1_zero_reg, s1_zero_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic                       channel_out_reg, channel_out_next;
    logic                       saturated_reg, saturated_next;

    // RAM ports
    logic                 coef_we, hist_we;
    logic [ADDR_W-1:0]    coef_addr, hist_addr;
    logic [SAMPLE_W-1:0]  coef_wdata, coef_rdata, hist_rdata;

    // Item decode
    logic                 accept;
    logic                 ch_ok, tap_ok;
    logic [CH_W-1:0]      ch_in;
    logic [TAP_W-1:0]     tap_in;
    logic [CNT_W-1:0]     taps_eff, fill_new;
    logic                 slot_free;
    logic                 in_range;
    logic signed [SAMPLE_W-1:0] hist_m;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign ch_in        = CH_W'(channel);
    assign tap_in       = TAP_W'(tap_index);
    assign ch_ok        = (32'(channel) < 32'(CHANNELS));
    assign tap_ok       = (32'(tap_index) < 32'(MAX_TAPS));
    assign slot_free    = !result_valid_reg || !result_stall;
    assign fill_new     = (fill_reg[ch_in] == FULL_FILL) ? FULL_FILL
                                                         : fill_reg[ch_in] + CNT_W'(1);

    // Tap count clamped to 1 .. MAX_TAPS
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_eff = CNT_W'(1);
        end
        else if (32'(tap_count_reg) > 32'(MAX_TAPS))
        begin
            taps_eff = FULL_FILL;
        end
        else
        begin
            taps_eff = CNT_W'(tap_count_reg);
        end
    end

    // Multiply stage: slots not written since the last clear count as zero
    assign hist_m    = s1_zero_reg ? '0 : $signed(hist_rdata);
    assign prod_next = $signed(coef_rdata) * hist_m;

    // Top bits above the Q1.23 result must be a pure sign extension
    assign in_range  = (&acc_reg[ACC_W-1 -: TOP_W]) || !(|acc_reg[ACC_W-1 -: TOP_W]);

    // Sequencer: next state, RAM ports and register updates
    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        k_next            = k_reg;
        pos_next          = pos_reg;
        ch_next           = ch_reg;
        taps_next         = taps_reg;
        fill_cur_next     = fill_cur_reg;
        ptr_next          = ptr_reg;
        fill_next         = fill_reg;
        tap_count_next    = tap_count_reg;
        s1_valid_next     = 1'b0;
        s2_valid_next     = s1_valid_reg;
        s1_zero_next      = 1'b0;
        result_valid_next = result_valid_reg && result_stall;
        sample_out_next   = sample_out_reg;
        channel_out_next  = channel_out_reg;
        saturated_next    = saturated_reg;
        acc_next          = s2_valid_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;

        coef_we    = 1'b0;
        coef_addr  = {ch_reg, k_reg[TAP_W-1:0]};
        coef_wdata = value;
        hist_we    = 1'b0;
        hist_addr  = {ch_reg, pos_reg};

        if (cfg_valid && cfg_ready)
        begin
            tap_count_next = tap_count;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                coef_we    = 1'b1;
                coef_addr  = clr_reg;
                coef_wdata = '0;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                coef_addr = {ch_in, tap_in};
                hist_addr = {ch_in, ptr_reg[ch_in]};
                if (accept && ch_ok)
                begin
                    case (action_t'(action))
                        ACT_COEF:
                        begin
                            coef_we = tap_ok;
                        end
                        ACT_SAMPLE:
                        begin
                            hist_we           = 1'b1;
                            ch_next           = ch_in;
                            k_next            = '0;
                            pos_next          = ptr_reg[ch_in];
                            taps_next         = taps_eff;
                            fill_cur_next     = fill_new;
                            fill_next[ch_in]  = fill_new;
                            ptr_next[ch_in]   = (ptr_reg[ch_in] == LAST_SLOT)
                                                ? '0 : ptr_reg[ch_in] + TAP_W'(1);
                            acc_next          = '0;
                            state_next        = ST_MAC;
                        end
                        ACT_CLEAR:
                        begin
                            fill_next[ch_in] = '0;
                            ptr_next[ch_in]  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_MAC:
            begin
                // one tap read per cycle, newest sample first
                s1_valid_next = 1'b1;
                s1_zero_next  = (k_reg >= fill_cur_reg);
                k_next        = k_reg + CNT_W'(1);
                pos_next      = (pos_reg == '0) ? LAST_SLOT : pos_reg - TAP_W'(1);
                if ((k_reg + CNT_W'(1)) == taps_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (slot_free)
                begin
                    result_valid_next = 1'b1;
                    channel_out_next  = ch_reg[0];
                    saturated_next    = !in_range;
                    if (in_range)
                    begin
                        sample_out_next = acc_reg[FRAC_BITS +: SAMPLE_W];
                    end
                    else
                    begin
                        sample_out_next = acc_reg[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            k_reg            <= '0;
            pos_reg          <= '0;
            ch_reg           <= '0;
            taps_reg         <= '0;
            fill_cur_reg     <= '0;
            tap_count_reg    <= TAP_COUNT_RESET;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < 2**CH_W; i++)
            begin
                ptr_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            k_reg            <= k_next;
            pos_reg          <= pos_next;
            ch_reg           <= ch_next;
            taps_reg         <= taps_next;
            fill_cur_reg     <= fill_cur_next;
            tap_count_reg    <= tap_count_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
            ptr_reg          <= ptr_next;
            fill_reg         <= fill_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        s1_zero_reg     <= s1_zero_next;
        prod_reg        <= prod_next;
        acc_reg         <= acc_next;
        sample_out_reg  <= sample_out_next;
        channel_out_reg <= channel_out_next;
        saturated_reg   <= saturated_next;
    end

    // Coefficient and history stores
    bfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .addr  (coef_addr),
        .wdata (coef_wdata),
        .rdata (coef_rdata)
    );

    bfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .addr  (hist_addr),
        .wdata (value),
        .rdata (hist_rdata)
    );

    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign channel_out  = channel_out_reg;
    assign saturated    = saturated_reg;

endmodule

`default_nettype wire

/* sv/bfc_checker.sv */
// Port-level assertions for the FIR convolver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bfc_checker
    import bfc_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_stall,
    input wire logic        [ACTION_W-1:0]    action,
    input wire logic                          channel,
    input wire logic                          result_valid,
    input wire logic                          result_stall,
    input wire logic signed [SAMPLE_W-1:0]    sample_out,
    input wire logic                          channel_out,
    input wire logic                          saturated
);

    logic item_take;
    logic sample_take;

    assign item_take   = item_valid && !item_stall;
    assign sample_take = item_take && (action == ACT_SAMPLE)
                         && (32'(channel) < 32'(CHANNELS));

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(sample_out)
                                         && $stable(channel_out) && $stable(saturated))
        else $error("stalled result changed");

    // A clipped sum shows one of the two limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> (sample_out == SAMPLE_MAX) || (sample_out == SAMPLE_MIN))
        else $error("saturated flag without limit value");

    // A sample item occupies the MAC loop on the following cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> item_stall)
        else $error("block free right after a sample item");

    // Coefficient writes and clears leave the block free on the following cycle
    a_short_items: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && ((action == ACT_COEF) || (action == ACT_CLEAR)) |=> !item_stall)
        else $error("block busy after a coefficient write or clear");

endmodule

bind block_fir_convolver bfc_checker #(
    .CHANNELS (CHANNELS)
) u_bfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .channel      (channel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .channel_out  (channel_out),
    .saturated    (saturated)
);

`default_nettype wire

/* tb/block_fir_convolver_tb.sv */
// Testbench for the FIR convolver: queued item driver, result monitor and tap-by-tap predictor.
`timescale 1ns / 1ps

module block_fir_convolver_tb;
    import bfc_pkg::*;

    localparam int N_TAPS       = DEF_MAX_TAPS;
    localparam int N_CH         = DEF_CHANNELS;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 500;

    typedef struct {
        action_t                     act;
        logic                        ch;
        logic [TAP_INDEX_W-1:0]      tap;
        logic signed [SAMPLE_W-1:0]  val;
    } fir_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0]  y;
        logic                        ch;
        logic                        sat;
    } fir_output_t;

    // Block ports
    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [TAP_COUNT_W-1:0]        cfg_taps     = '0;
    logic                          item_valid   = 1'b0;
    logic                          item_stall;
    logic [ACTION_W-1:0]           action       = '0;
    logic                          channel      = 1'b0;
    logic [TAP_INDEX_W-1:0]        tap_index    = '0;
    logic signed [SAMPLE_W-1:0]    value        = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]    sample_out;
    logic                          channel_out;
    logic                          saturated;

    // Stimulus and checking state
    fir_item_t                     items_to_send[$];
    fir_output_t                   expected_outputs[$];
    int                            mismatches     = 0;
    int                            send_idle_pct  = 0;
    int                            recv_stall_pct = 0;
    logic                          item_taken     = 1'b0;
    logic                          hold_arm       = 1'b0;
    logic                          hold_on        = 1'b0;

    // Predictor copy of the block state
    logic signed [SAMPLE_W-1:0]    coef_mem [N_CH][N_TAPS];
    logic signed [SAMPLE_W-1:0]    hist_mem [N_CH][N_TAPS];
    int unsigned                   newest_slot [N_CH];
    logic [TAP_COUNT_W-1:0]        tap_setting = TAP_COUNT_RESET;

    block_fir_convolver #(
        .MAX_TAPS (N_TAPS),
        .CHANNELS (N_CH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .tap_count    (cfg_taps),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .channel      (channel),
        .tap_index    (tap_index),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .channel_out  (channel_out),
        .saturated    (saturated)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Taps actually walked for a given register value
    function automatic int unsigned taps_in_use(input logic [TAP_COUNT_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > N_TAPS)
            return N_TAPS;
        return setting;
    endfunction

    // Apply one accepted item to the predictor; a sample queues its convolved output
    function automatic void convolve_item(input fir_item_t it);
        int unsigned n_taps;
        int unsigned slot;
        int unsigned k;
        longint      acc;
        longint      y;
        fir_output_t r;
        n_taps = taps_in_use(tap_setting);
        case (it.act)
            ACT_COEF:
                coef_mem[it.ch][it.tap] = it.val;
            ACT_CLEAR:
            begin
                for (k = 0; k < N_TAPS; k++)
                    hist_mem[it.ch][k] = '0;
                newest_slot[it.ch] = 0;
            end
            ACT_SAMPLE:
            begin
                slot = newest_slot[it.ch];
                hist_mem[it.ch][slot] = it.val;
                acc = 0;
                for (k = 0; k < n_taps; k++)
                begin
                    acc += longint'(coef_mem[it.ch][k]) * longint'(hist_mem[it.ch][slot]);
                    slot = (slot == 0) ? N_TAPS - 1 : slot - 1;
                end
                // floor by 23 bits, then clip
                y = acc >>> FRAC_BITS;
                r.sat = 1'b0;
                if (y > longint'(SAMPLE_MAX))
                begin
                    y = SAMPLE_MAX;
                    r.sat = 1'b1;
                end
                else if (y < longint'(SAMPLE_MIN))
                begin
                    y = SAMPLE_MIN;
                    r.sat = 1'b1;
                end
                r.y  = y[SAMPLE_W-1:0];
                r.ch = it.ch;
                expected_outputs.push_back(r);
                newest_slot[it.ch] = (newest_slot[it.ch] + 1 >= N_TAPS) ? 0
                                     : newest_slot[it.ch] + 1;
            end
            default:
                ;
        endcase
    endfunction

    // Extremes and small values in four of ten draws, the rest full range
    function automatic logic signed [SAMPLE_W-1:0] random_value();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2, 3:
            begin
                v = SAMPLE_W'($urandom_range(32));
                v = v - 24'sd16;
            end
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // Coefficient writes mostly land inside the taps in use
    function automatic fir_item_t random_item(input int unsigned n_taps);
        fir_item_t   it;
        int unsigned roll;
        roll   = $urandom_range(99);
        it.ch  = 1'($urandom_range(1));
        it.tap = TAP_INDEX_W'($urandom_range(N_TAPS - 1));
        it.val = random_value();
        if (roll < 30)
        begin
            it.act = ACT_COEF;
            if ($urandom_range(4) != 0)
                it.tap = TAP_INDEX_W'($urandom_range(n_taps - 1));
        end
        else if (roll < 88)
            it.act = ACT_SAMPLE;
        else if (roll < 95)
            it.act = ACT_CLEAR;
        else
            it.act = ACT_NONE;
        return it;
    endfunction

    function automatic void queue_item(input action_t a, input logic c,
                                       input logic [TAP_INDEX_W-1:0] t,
                                       input logic signed [SAMPLE_W-1:0] v);
        fir_item_t it;
        it.act = a;
        it.ch  = c;
        it.tap = t;
        it.val = v;
        items_to_send.push_back(it);
    endfunction

    // Item driver: holds a stalled item, otherwise idles or offers the next one
    always @(negedge clk)
    begin : feed_items
        fir_item_t nxt;
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && !item_taken)
            ;
        else if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            nxt = items_to_send.pop_front();
            action     <= nxt.act;
            channel    <= nxt.ch;
            tap_index  <= nxt.tap;
            value      <= nxt.val;
            item_valid <= 1'b1;
        end
        else
            item_valid <= 1'b0;
    end

    // Receiver stall: random, or forced high during the long hold-off
    always @(negedge clk)
    begin
        if (hold_on)
            result_stall <= 1'b1;
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Long hold-off, counted here once armed
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // Monitor: predict on accepted items, check accepted outputs
    always @(posedge clk)
    begin : watch_ports
        fir_item_t   cur;
        fir_output_t want;
        item_taken <= item_valid && !item_stall;
        if (rst_n && item_valid && !item_stall)
        begin
            cur.act = action_t'(action);
            cur.ch  = channel;
            cur.tap = tap_index;
            cur.val = value;
            convolve_item(cur);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                $display("%0t: unexpected output: sample %0d channel %0d saturated %0b",
                         $time, sample_out, channel_out, saturated);
                mismatches++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (sample_out !== want.y)
                begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, want.y, sample_out);
                    mismatches++;
                end
                if (channel_out !== want.ch)
                begin
                    $display("%0t: channel_out expected %0d actual %0d",
                             $time, want.ch, channel_out);
                    mismatches++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.sat, saturated);
                    mismatches++;
                end
            end
        end
    end

    // Wait for all items sent and all outputs back, then let the block settle
    task automatic wait_drained();
        while (items_to_send.size() != 0 || item_valid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_taps  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tap_setting = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random phase at a given tap setting and idling mix
    task automatic random_phase(input logic [TAP_COUNT_W-1:0] taps_v, input int idle_v,
                                input int stall_v, input int count_v, input bit hold_v);
        int unsigned n_eff;
        wait_drained();
        write_tap_count(taps_v);
        send_idle_pct  = idle_v;
        recv_stall_pct = stall_v;
        n_eff = taps_in_use(taps_v);
        if (hold_v)
            hold_arm = 1'b1;
        repeat (count_v)
            items_to_send.push_back(random_item(n_eff));
    endtask

    // Run limit
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Sequencer
    initial
    begin : sequencer
        int c;
        int k;
        for (c = 0; c < N_CH; c++)
        begin
            for (k = 0; k < N_TAPS; k++)
            begin
                coef_mem[c][k] = '0;
                hist_mem[c][k] = '0;
            end
            newest_slot[c] = 0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset tap count (all taps)
        queue_item(ACT_SAMPLE, 1'b0, 10'd0, 24'sd1);
        queue_item(ACT_COEF,   1'b0, 10'd0, SAMPLE_MAX);
        queue_item(ACT_SAMPLE, 1'b0, 10'd0, SAMPLE_MAX);
        queue_item(ACT_COEF,   1'b0, 10'd0, SAMPLE_MIN);
        // min times min clips high
        queue_item(ACT_SAMPLE, 1'b0, 10'd0, SAMPLE_MIN);
        queue_item(ACT_SAMPLE, 1'b0, 10'd0, SAMPLE_MAX);
        // last tap position
        queue_item(ACT_COEF,   1'b0, 10'd1023, SAMPLE_MIN);
        queue_item(ACT_SAMPLE, 1'b0, 10'd0, -24'sd1);
        // tiny negative sum floors to -1
        queue_item(ACT_COEF,   1'b1, 10'd0, -24'sd1);
        queue_item(ACT_SAMPLE, 1'b1, 10'd512, 24'sd1);
        // several large terms clip high
        queue_item(ACT_COEF,   1'b1, 10'd1, SAMPLE_MIN);
        queue_item(ACT_COEF,   1'b1, 10'd2, SAMPLE_MIN);
        queue_item(ACT_SAMPLE, 1'b1, 10'd0, SAMPLE_MIN);
        queue_item(ACT_SAMPLE, 1'b1, 10'd0, SAMPLE_MIN);
        // several large terms clip low
        queue_item(ACT_COEF,   1'b1, 10'd0, SAMPLE_MAX);
        queue_item(ACT_COEF,   1'b1, 10'd1, SAMPLE_MAX);
        queue_item(ACT_COEF,   1'b1, 10'd2, SAMPLE_MAX);
        queue_item(ACT_SAMPLE, 1'b1, 10'd0, SAMPLE_MIN);
        // clear keeps coefficients, drops history
        queue_item(ACT_CLEAR,  1'b1, 10'd1023, SAMPLE_MAX);
        queue_item(ACT_SAMPLE, 1'b1, 10'd0, 24'sd4);
        // unused action is ignored
        queue_item(ACT_NONE,   1'b1, 10'd1023, SAMPLE_MIN);
        queue_item(ACT_CLEAR,  1'b0, 10'd0, 24'sd0);
        queue_item(ACT_SAMPLE, 1'b0, 10'd341, 24'sh2AAAAA);

        // Random phases: tap setting, sender idle %, receiver stall %, items, hold-off
        random_phase(11'd0,    0,  0,  60, 1'b0);
        random_phase(11'd2047, 26, 26, 10, 1'b0);
        random_phase(11'd5,    86, 0,  100, 1'b0);
        random_phase(11'd1,    0,  86, 80, 1'b0);
        random_phase(11'd16,   26, 26, 100, 1'b0);
        random_phase(11'd4,    0,  0,  60, 1'b1);
        random_phase(11'd33,   0,  0,  80, 1'b0);
        random_phase(11'd1024, 0,  0,  8,  1'b0);
        random_phase(11'd9,    0,  86, 80, 1'b0);

        wait_drained();
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
